### hdl/assert_macros.svh
// assertion macros used by the checker file t2b_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check that is off while reset is held
`define T2B_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs during reset
`define T2B_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/t2b_pkg.sv
// types, codes and character tables for the braille translation unit
// no dependencies
package t2b_pkg;

    localparam int DOTS_W = 6;

    localparam logic [1:0] CFG_CAPITAL_SIGN = 2'd0;
    localparam logic [1:0] CFG_NUMBER_SIGN  = 2'd1;
    localparam logic [1:0] CFG_LETTER_SIGN  = 2'd2;

    localparam logic [DOTS_W-1:0] CAPITAL_SIGN_RST = 6'd32;
    localparam logic [DOTS_W-1:0] NUMBER_SIGN_RST  = 6'd39;
    localparam logic [DOTS_W-1:0] LETTER_SIGN_RST  = 6'd48;

    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_NEWLINE = 8'h0A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_ONE     = 8'h31;
    localparam logic [7:0] ASCII_NINE    = 8'h39;

    // output slots of one character, in emission order
    typedef enum logic [1:0] {
        STEP_SIGN = 2'd0,
        STEP_CAP1 = 2'd1,
        STEP_CAP2 = 2'd2,
        STEP_CHAR = 2'd3
    } t_step;

    typedef struct packed {
        logic              present;
        logic [DOTS_W-1:0] dots;
        logic              brk;
        logic              clr_cap;
        logic              dig;
        logic              word_end;
    } t_emit;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= ASCII_LOWER_A) && (c <= ASCII_LOWER_Z);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= ASCII_UPPER_A) && (c <= ASCII_UPPER_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
    endfunction

    // grade-1 cells of a..z
    function automatic logic [DOTS_W-1:0] alpha_cell(input logic [4:0] idx);
        logic [DOTS_W-1:0] d;
        case (idx)
            5'd0:    d = 6'h01;
            5'd1:    d = 6'h03;
            5'd2:    d = 6'h09;
            5'd3:    d = 6'h19;
            5'd4:    d = 6'h11;
            5'd5:    d = 6'h0B;
            5'd6:    d = 6'h1B;
            5'd7:    d = 6'h13;
            5'd8:    d = 6'h0A;
            5'd9:    d = 6'h1A;
            5'd10:   d = 6'h05;
            5'd11:   d = 6'h07;
            5'd12:   d = 6'h0D;
            5'd13:   d = 6'h1D;
            5'd14:   d = 6'h15;
            5'd15:   d = 6'h0F;
            5'd16:   d = 6'h1F;
            5'd17:   d = 6'h17;
            5'd18:   d = 6'h0E;
            5'd19:   d = 6'h1E;
            5'd20:   d = 6'h25;
            5'd21:   d = 6'h27;
            5'd22:   d = 6'h3A;
            5'd23:   d = 6'h2D;
            5'd24:   d = 6'h3D;
            5'd25:   d = 6'h35;
            default: d = 6'h00;
        endcase
        return d;
    endfunction

endpackage

### hdl/t2b_cell.sv
// one position of the word buffer chain: holds a byte, shifts toward the head
// depends on t2b_pkg
module t2b_cell
    import t2b_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 4
) (
    input  logic          i_clk,
    input  logic          i_load,
    input  logic          i_shift,
    input  logic [CW-1:0] i_count,
    input  logic [7:0]    i_byte,
    input  logic [7:0]    i_next_byte,
    input  logic          i_next_lower,
    output logic [7:0]    o_byte,
    output logic          o_lower_ahead
);

    logic [7:0] r_byte;
    logic       w_occupied;

    assign w_occupied = CW'(IDX) < i_count;

    always_ff @(posedge i_clk) begin
        if (i_load && (i_count == CW'(IDX))) begin
            r_byte <= i_byte;
        end else if (i_shift) begin
            r_byte <= i_next_byte;
        end
    end

    // lowercase anywhere from this position to the end of the word
    assign o_lower_ahead = (w_occupied && is_lower(r_byte)) || i_next_lower;
    assign o_byte        = r_byte;

endmodule

### hdl/t2b_emit.sv
// cell selection for one slot of the character at the head of the chain
// depends on t2b_pkg
module t2b_emit
    import t2b_pkg::*;
(
    input  logic [7:0]        i_byte,
    input  logic              i_no_lower_ahead,
    input  logic              i_prev_digit,
    input  logic              i_cap_en,
    input  t_step             i_step,
    input  logic [DOTS_W-1:0] i_capital_sign,
    input  logic [DOTS_W-1:0] i_number_sign,
    input  logic [DOTS_W-1:0] i_letter_sign,
    output t_emit             o_emit
);

    logic       w_dig;
    logic       w_up;
    logic       w_low;
    logic [7:0] w_ofs;

    assign w_dig = is_digit(i_byte);
    assign w_up  = is_upper(i_byte);
    assign w_low = is_lower(i_byte);

    always_comb begin
        if (w_low) begin
            w_ofs = i_byte - ASCII_LOWER_A;
        end else if (w_up) begin
            w_ofs = i_byte - ASCII_UPPER_A;
        end else if (i_byte == ASCII_ZERO) begin
            w_ofs = 8'd9;
        end else begin
            w_ofs = i_byte - ASCII_ONE;
        end
    end

    always_comb begin
        o_emit          = '0;
        o_emit.dig      = w_dig;
        o_emit.word_end = (i_byte == ASCII_SPACE) || (i_byte == ASCII_NEWLINE);
        case (i_step)
            STEP_SIGN: begin
                o_emit.present = i_prev_digit != w_dig;
                o_emit.dots    = i_prev_digit ? i_letter_sign : i_number_sign;
            end
            STEP_CAP1: begin
                o_emit.present = w_up && i_cap_en;
                o_emit.dots    = i_capital_sign;
            end
            STEP_CAP2: begin
                o_emit.present = w_up && i_cap_en && i_no_lower_ahead;
                o_emit.dots    = i_capital_sign;
                o_emit.clr_cap = w_up && i_cap_en && i_no_lower_ahead;
            end
            STEP_CHAR: begin
                if (w_low || w_up || w_dig) begin
                    o_emit.present = 1'b1;
                    o_emit.dots    = alpha_cell(w_ofs[4:0]);
                end else if (i_byte == ASCII_SPACE) begin
                    o_emit.present = 1'b1;
                end else if (i_byte == ASCII_NEWLINE) begin
                    o_emit.present = 1'b1;
                    o_emit.brk     = 1'b1;
                end
            end
            default: o_emit.present = 1'b0;
        endcase
    end

endmodule

### hdl/text_to_braille_cells_unit.sv
// channel   dir  tdata                    tuser           tlast
// s_axis    in   [7:0] text_byte          -               end_of_text
// m_axis    out  [5:0] dots, [7:6] zero   [0] line_break  last_of_flush
// cfg       in   we / addr[1:0] / wdata[5:0] (capital, number, letter sign)
//
// a byte that does not end a word is stored in the chain.
// a flush steps each buffered byte, then any space or newline that ended the
// word, through its output slots; m_axis back-pressure stalls the sequencer.
// s_axis is ready only while no flush runs. synchronous reset, no clearing pass.
// depends on t2b_pkg, t2b_cell, t2b_emit
module text_to_braille_cells_unit
    import t2b_pkg::*;
#(
    parameter int WORD_MAX = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [7:0]        i_s_axis_tdata,  // [7:0] text_byte
    input  logic              i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [7:0]        o_m_axis_tdata,  // [5:0] dots, [7:6] zero
    output logic              o_m_axis_tuser,  // [0] line_break
    output logic              o_m_axis_tlast,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_addr,
    input  logic [DOTS_W-1:0] i_cfg_wdata
);

    localparam int CW = $clog2(WORD_MAX + 1);

    typedef enum logic {
        S_IDLE,
        S_FLUSH
    } t_state;

    t_state            r_state;
    t_step             r_step;
    logic [CW-1:0]     r_count;
    logic              r_tail_pending;
    logic [7:0]        r_tail_byte;
    logic              r_eot;
    logic              r_prev_digit;
    logic              r_cap_en;
    logic              r_held_valid;
    logic [DOTS_W-1:0] r_held_dots;
    logic              r_held_brk;
    logic              r_out_valid;
    logic [DOTS_W-1:0] r_out_dots;
    logic              r_out_brk;
    logic              r_out_last;
    logic [DOTS_W-1:0] r_capital_sign;
    logic [DOTS_W-1:0] r_number_sign;
    logic [DOTS_W-1:0] r_letter_sign;

    logic [7:0]        w_byte  [WORD_MAX+1];
    logic              w_lower [WORD_MAX+1];
    logic              w_accept;
    logic              w_sep;
    logic              w_load;
    logic              w_shift;
    logic              w_have_byte;
    logic              w_out_free;
    logic              w_advance;
    logic              w_out_load;
    logic [7:0]        w_head_byte;
    logic              w_head_none;
    logic [CW:0]       w_count_inc;
    t_emit             w_emit;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sep       = (i_s_axis_tdata == ASCII_SPACE) || (i_s_axis_tdata == ASCII_NEWLINE);
    assign w_load      = w_accept && !w_sep;
    assign w_count_inc = {1'b0, r_count} + 1'b1;
    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_have_byte = (r_count != '0) || r_tail_pending;
    assign w_advance   = !w_emit.present || !r_held_valid || w_out_free;
    assign w_shift     = (r_state == S_FLUSH) && (r_count != '0)
                         && (r_step == STEP_CHAR) && w_advance;
    // held cell moves to the output register
    assign w_out_load  = (r_state == S_FLUSH) && r_held_valid
                         && (w_have_byte ? (w_advance && w_emit.present) : w_out_free);

    assign w_byte[WORD_MAX]  = '0;
    assign w_lower[WORD_MAX] = 1'b0;

    for (genvar g = 0; g < WORD_MAX; g++) begin : g_cells
        t2b_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_load        (w_load),
            .i_shift       (w_shift),
            .i_count       (r_count),
            .i_byte        (i_s_axis_tdata),
            .i_next_byte   (w_byte[g+1]),
            .i_next_lower  (w_lower[g+1]),
            .o_byte        (w_byte[g]),
            .o_lower_ahead (w_lower[g])
        );
    end

    // buffered word first, then the space or newline that ended it
    assign w_head_byte = (r_count != '0) ? w_byte[0] : r_tail_byte;
    assign w_head_none = (r_count != '0) ? !w_lower[0] : 1'b1;

    t2b_emit u_emit (
        .i_byte           (w_head_byte),
        .i_no_lower_ahead (w_head_none),
        .i_prev_digit     (r_prev_digit),
        .i_cap_en         (r_cap_en),
        .i_step           (r_step),
        .i_capital_sign   (r_capital_sign),
        .i_number_sign    (r_number_sign),
        .i_letter_sign    (r_letter_sign),
        .o_emit           (w_emit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capital_sign <= CAPITAL_SIGN_RST;
            r_number_sign  <= NUMBER_SIGN_RST;
            r_letter_sign  <= LETTER_SIGN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CAPITAL_SIGN: r_capital_sign <= i_cfg_wdata;
                CFG_NUMBER_SIGN:  r_number_sign  <= i_cfg_wdata;
                CFG_LETTER_SIGN:  r_letter_sign  <= i_cfg_wdata;
                default:          r_letter_sign  <= r_letter_sign;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_step         <= STEP_SIGN;
            r_count        <= '0;
            r_tail_pending <= 1'b0;
            r_eot          <= 1'b0;
            r_prev_digit   <= 1'b0;
            r_cap_en       <= 1'b1;
            r_held_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_eot  <= i_s_axis_tlast;
                        r_step <= STEP_SIGN;
                        if (w_sep) begin
                            r_tail_pending <= 1'b1;
                            r_tail_byte    <= i_s_axis_tdata;
                            r_state        <= S_FLUSH;
                        end else begin
                            r_count <= w_count_inc[CW-1:0];
                            if ((w_count_inc == (CW+1)'(WORD_MAX)) || i_s_axis_tlast) begin
                                r_state <= S_FLUSH;
                            end
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_have_byte) begin
                        if (w_advance) begin
                            if (w_emit.present) begin
                                if (r_held_valid) begin
                                    r_out_dots  <= r_held_dots;
                                    r_out_brk   <= r_held_brk;
                                    r_out_last  <= 1'b0;
                                end
                                r_held_valid <= 1'b1;
                                r_held_dots  <= w_emit.dots;
                                r_held_brk   <= w_emit.brk;
                            end
                            case (r_step)
                                STEP_SIGN: r_step <= STEP_CAP1;
                                STEP_CAP1: r_step <= STEP_CAP2;
                                STEP_CAP2: begin
                                    r_step <= STEP_CHAR;
                                    if (w_emit.clr_cap) begin
                                        r_cap_en <= 1'b0;
                                    end
                                end
                                STEP_CHAR: begin
                                    r_step       <= STEP_SIGN;
                                    r_prev_digit <= w_emit.dig;
                                    if (w_emit.word_end) begin
                                        r_cap_en <= 1'b1;
                                    end
                                    if (r_count != '0) begin
                                        r_count <= r_count - 1'b1;
                                    end else begin
                                        r_tail_pending <= 1'b0;
                                    end
                                end
                                default: r_step <= STEP_SIGN;
                            endcase
                        end
                    end else if (!r_held_valid || w_out_free) begin
                        // release the held cell as the final one of this transfer
                        if (r_held_valid) begin
                            r_out_dots  <= r_held_dots;
                            r_out_brk   <= r_held_brk;
                            r_out_last  <= 1'b1;
                        end
                        r_held_valid <= 1'b0;
                        r_state      <= S_IDLE;
                        if (r_eot) begin
                            r_prev_digit <= 1'b0;
                            r_cap_en     <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_dots};
    assign o_m_axis_tuser  = r_out_brk;
    assign o_m_axis_tlast  = r_out_last;

endmodule

### hdl/t2b_checker.sv
// port-level checks for the braille translation unit, bound to the top level
// depends on t2b_pkg, assert_macros.svh and text_to_braille_cells_unit
`include "assert_macros.svh"

module t2b_checker
    import t2b_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tuser,
    input logic       o_m_axis_tlast
);

    logic        w_sep_xfer;
    logic        w_out_stall;
    logic [10:0] w_out_word;
    logic        w_cell_ok;

    assign w_sep_xfer  = i_s_axis_tvalid && o_s_axis_tready
                         && ((i_s_axis_tdata == ASCII_SPACE) || (i_s_axis_tdata == ASCII_NEWLINE));
    assign w_out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_word  = {o_m_axis_tvalid, o_m_axis_tlast, o_m_axis_tuser, o_m_axis_tdata};
    assign w_cell_ok   = (o_m_axis_tdata[7:6] == 2'b00)
                         && (!o_m_axis_tuser || (o_m_axis_tdata == 8'h00));

    // a stalled result keeps its payload
    `T2B_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> $stable(w_out_word), "result not held")

    // a line break carries a blank cell, pad bits stay zero
    `T2B_ASSERT(a_brk_blank, i_clk, i_rst_n, o_m_axis_tvalid |-> w_cell_ok, "bad cell payload")

    // a word separator always starts a flush
    `T2B_ASSERT(a_sep_flush, i_clk, i_rst_n, w_sep_xfer |=> !o_s_axis_tready, "flush not started")

    // no result right after reset
    `T2B_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "valid after reset")

endmodule

bind text_to_braille_cells_unit t2b_checker u_t2b_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
